// File: rtl/omaf_pkg.sv
// ----------------------------------------------------------------------------
// omaf_pkg
// Shared types and constants for the OHLC moving-average forecaster.
// ----------------------------------------------------------------------------
`default_nettype none

package omaf_pkg;

  localparam int TEMP_W    = 16;
  localparam int YEAR_W    = 12;
  localparam int NUM_LANES = 4;
  localparam int TDATA_W   = 80;

  // lane order inside a candle, lowest first
  localparam int LANE_OPEN  = 0;
  localparam int LANE_HIGH  = 1;
  localparam int LANE_LOW   = 2;
  localparam int LANE_CLOSE = 3;

  typedef logic [TEMP_W-1:0] temp_t;
  typedef logic [YEAR_W-1:0] year_t;

  // element [LANE_OPEN] sits in the lowest bits
  typedef temp_t [NUM_LANES-1:0] candle_t;

  typedef struct packed {
    year_t year;
    logic  last;
    logic  few;
  } job_ctrl_t;

endpackage

`default_nettype wire

// File: rtl/omaf_window.sv
// ----------------------------------------------------------------------------
// omaf_window
// Sliding window store, running sums and end-of-series sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module omaf_window #(
  parameter int WINDOW  = 8,
  parameter int HORIZON = 8,
  parameter int SUMW    = 16 + $clog2(WINDOW)
) (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  wire                        in_valid_i,
  input  omaf_pkg::candle_t          in_candle_i,
  input  omaf_pkg::year_t            in_year_i,
  input  wire                        in_eos_i,
  output logic                       in_take_o,
  input  omaf_pkg::candle_t          prev_i,
  input  wire                        job_take_i,
  output logic                       job_valid_o,
  output logic [3:0][SUMW-1:0]       job_sums_o,
  output omaf_pkg::job_ctrl_t        job_ctrl_o
);

  localparam int IDXW = $clog2(WINDOW);
  localparam int CNTW = $clog2(WINDOW + 1);
  localparam int HCW  = $clog2(HORIZON + 1);

  omaf_pkg::candle_t      store_q [WINDOW];
  logic [IDXW-1:0]        head_q, head_d, wr_idx;
  logic [CNTW-1:0]        fill_q, fill_d;
  logic [3:0][SUMW-1:0]   sums_q, sums_d, sums_push;
  omaf_pkg::year_t        newest_q, newest_d, newest_after;
  logic                   fc_q, fc_d;
  logic                   hmode_q, hmode_d;
  logic [HCW-1:0]         hcnt_q, hcnt_d;
  logic                   job_valid_q, job_valid_d;
  logic [3:0][SUMW-1:0]   job_sums_q, job_sums_d;
  omaf_pkg::job_ctrl_t    job_ctrl_q, job_ctrl_d;

  logic                   full, full_after, job_free, take, hstep, push, h_last;
  omaf_pkg::candle_t      push_val, old_val;
  omaf_pkg::year_t        push_year;

  assign full       = (fill_q == CNTW'(WINDOW));
  assign full_after = full || (fill_q == CNTW'(WINDOW - 1));
  assign job_free   = !job_valid_q || job_take_i;
  assign take       = !hmode_q && in_valid_i && job_free;
  assign hstep      = hmode_q && !job_valid_q;
  // horizon steps push the previous forecast only once one exists
  assign push       = take || (hstep && fc_q);
  assign h_last     = (hcnt_q == HCW'(HORIZON - 1));
  assign in_take_o  = take;

  assign push_val   = hmode_q ? prev_i : in_candle_i;
  assign push_year  = hmode_q ? (newest_q + omaf_pkg::YEAR_W'(1)) : in_year_i;
  assign old_val    = store_q[head_q];
  assign wr_idx     = full ? head_q : fill_q[IDXW-1:0];
  assign newest_after = push ? push_year : newest_q;

  always_comb begin
    for (int c = 0; c < omaf_pkg::NUM_LANES; c++) begin
      if (full) begin
        sums_push[c] = sums_q[c]
                     - {{IDXW{old_val[c][omaf_pkg::TEMP_W-1]}}, old_val[c]}
                     + {{IDXW{push_val[c][omaf_pkg::TEMP_W-1]}}, push_val[c]};
      end else begin
        sums_push[c] = sums_q[c]
                     + {{IDXW{push_val[c][omaf_pkg::TEMP_W-1]}}, push_val[c]};
      end
    end
  end

  always_comb begin
    head_d      = head_q;
    fill_d      = fill_q;
    sums_d      = sums_q;
    newest_d    = newest_q;
    fc_d        = fc_q;
    hmode_d     = hmode_q;
    hcnt_d      = hcnt_q;
    job_valid_d = job_valid_q && !job_take_i;
    job_sums_d  = job_sums_q;
    job_ctrl_d  = job_ctrl_q;

    if (push) begin
      sums_d   = sums_push;
      newest_d = push_year;
      if (full) begin
        head_d = (head_q == IDXW'(WINDOW - 1)) ? '0 : head_q + IDXW'(1);
      end else begin
        fill_d = fill_q + CNTW'(1);
      end
    end

    if (take) begin
      if (full) begin
        // window was already full: one forecast per candle
        job_valid_d     = 1'b1;
        job_sums_d      = sums_push;
        job_ctrl_d.year = in_year_i + omaf_pkg::YEAR_W'(1);
        job_ctrl_d.last = 1'b0;
        job_ctrl_d.few  = 1'b0;
        fc_d            = 1'b1;
      end
      if (in_eos_i) begin
        if (full_after) begin
          hmode_d = 1'b1;
          hcnt_d  = '0;
        end else begin
          // series ended short
          job_valid_d     = 1'b1;
          job_ctrl_d.year = '0;
          job_ctrl_d.last = 1'b1;
          job_ctrl_d.few  = 1'b1;
          head_d   = '0;
          fill_d   = '0;
          sums_d   = '0;
          newest_d = '0;
          fc_d     = 1'b0;
        end
      end
    end else if (hstep) begin
      job_valid_d     = 1'b1;
      job_sums_d      = push ? sums_push : sums_q;
      job_ctrl_d.year = newest_after + omaf_pkg::YEAR_W'(1);
      job_ctrl_d.last = h_last;
      job_ctrl_d.few  = 1'b0;
      fc_d            = 1'b1;
      hcnt_d          = hcnt_q + HCW'(1);
      if (h_last) begin
        hmode_d  = 1'b0;
        head_d   = '0;
        fill_d   = '0;
        sums_d   = '0;
        newest_d = '0;
        fc_d     = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= '0;
      fill_q      <= '0;
      sums_q      <= '0;
      newest_q    <= '0;
      fc_q        <= 1'b0;
      hmode_q     <= 1'b0;
      hcnt_q      <= '0;
      job_valid_q <= 1'b0;
    end else begin
      head_q      <= head_d;
      fill_q      <= fill_d;
      sums_q      <= sums_d;
      newest_q    <= newest_d;
      fc_q        <= fc_d;
      hmode_q     <= hmode_d;
      hcnt_q      <= hcnt_d;
      job_valid_q <= job_valid_d;
    end
  end

  // window entries and job payload need no reset
  always_ff @(posedge clk_i) begin
    if (push) begin
      store_q[wr_idx] <= push_val;
    end
    job_sums_q <= job_sums_d;
    job_ctrl_q <= job_ctrl_d;
  end

  assign job_valid_o = job_valid_q;
  assign job_sums_o  = job_sums_q;
  assign job_ctrl_o  = job_ctrl_q;

endmodule

`default_nettype wire

// File: rtl/omaf_forecast.sv
// ----------------------------------------------------------------------------
// omaf_forecast
// Floored window averages by reciprocal multiply, result register.
// ----------------------------------------------------------------------------
`default_nettype none

module omaf_forecast #(
  parameter int WINDOW = 8,
  parameter int SUMW   = 16 + $clog2(WINDOW)
) (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    job_valid_i,
  input  wire [3:0][SUMW-1:0]    job_sums_i,
  input  omaf_pkg::job_ctrl_t    job_ctrl_i,
  output logic                   job_take_o,
  input  wire                    out_ready_i,
  output logic                   out_valid_o,
  output omaf_pkg::candle_t      out_vals_o,
  output omaf_pkg::job_ctrl_t    out_ctrl_o,
  output omaf_pkg::candle_t      prev_o
);

  // floor(s/W) = floor((s + W*2^15) / W) - 2^15, the biased value is
  // nonnegative and below 2^SUMW, so ceil(2^SHIFT/W) gives an exact quotient
  localparam int SHIFT  = SUMW + $clog2(WINDOW);
  localparam int PRODW  = 2 * SUMW + 1;
  localparam longint unsigned RECIP_L =
    ((longint'(1) << SHIFT) + longint'(WINDOW) - 1) / longint'(WINDOW);
  localparam logic [SUMW:0]   RECIP  = (SUMW + 1)'(RECIP_L);
  localparam logic [SUMW-1:0] OFFSET = SUMW'(WINDOW * 32768);

  logic                  out_valid_q;
  omaf_pkg::candle_t     out_vals_q, prev_q, avg;
  omaf_pkg::job_ctrl_t   out_ctrl_q;
  logic [SUMW-1:0]       biased [omaf_pkg::NUM_LANES];
  logic [PRODW-1:0]      prod   [omaf_pkg::NUM_LANES];
  logic [omaf_pkg::TEMP_W-1:0] quo [omaf_pkg::NUM_LANES];

  assign job_take_o = job_valid_i && (!out_valid_q || out_ready_i);

  always_comb begin
    for (int c = 0; c < omaf_pkg::NUM_LANES; c++) begin
      biased[c] = job_sums_i[c] + OFFSET;
      prod[c]   = PRODW'(biased[c]) * PRODW'(RECIP);
      quo[c]    = prod[c][SHIFT +: omaf_pkg::TEMP_W];
      // remove the bias: subtract 2^15 modulo 2^16
      avg[c]    = {~quo[c][omaf_pkg::TEMP_W-1], quo[c][omaf_pkg::TEMP_W-2:0]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (job_take_o) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (job_take_o) begin
      out_vals_q <= job_ctrl_i.few ? '0 : avg;
      out_ctrl_q <= job_ctrl_i;
      prev_q     <= avg;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_vals_o  = out_vals_q;
  assign out_ctrl_o  = out_ctrl_q;
  assign prev_o      = prev_q;

endmodule

`default_nettype wire

// File: rtl/ohlc_moving_average_forecast.sv
// ----------------------------------------------------------------------------
// ohlc_moving_average_forecast
// An accepted candle passes the input, window job and result registers.
// Throughput: one candle per cycle unless the output stalls or an end-of-series
// burst runs, set by the add-subtract on each running sum. End of series:
// HORIZON forecasts, each a window update, then a reciprocal multiply feeding
// back, input held meanwhile. Reset: asynchronous, clears handshakes, counters
// and sums; window store entries are not reset and are only read once written.
// ----------------------------------------------------------------------------
`default_nettype none

module ohlc_moving_average_forecast #(
  parameter int WINDOW  = 8,
  parameter int HORIZON = 8
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  // input candles
  input  wire         s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // [15:0] open_temp, [31:16] high_temp, [47:32] low_temp,
  // [63:48] close_temp, [75:64] year_num, [79:76] zero
  input  wire  [79:0] s_axis_tdata_i,
  input  wire         s_axis_tlast_i,   // end_of_series
  // forecasts
  output logic        m_axis_tvalid_o,
  input  wire         m_axis_tready_i,
  // [15:0] pred_open, [31:16] pred_high, [47:32] pred_low,
  // [63:48] pred_close, [75:64] pred_year, [79:76] zero
  output logic [79:0] m_axis_tdata_o,
  output logic        m_axis_tlast_o,   // run_last
  output logic [0:0]  m_axis_tuser_o    // [0] too_few
);

  localparam int SUMW = 16 + $clog2(WINDOW);
  localparam int CW   = omaf_pkg::NUM_LANES * omaf_pkg::TEMP_W;

  // input register: decouples the slave side from the window stage
  logic                  in_valid_q;
  omaf_pkg::candle_t     in_candle_q;
  omaf_pkg::year_t       in_year_q;
  logic                  in_eos_q;
  logic                  in_take;

  // window stage -> forecast stage
  logic                  job_valid, job_take;
  logic [3:0][SUMW-1:0]  job_sums;
  omaf_pkg::job_ctrl_t   job_ctrl;

  // forecast stage -> ports, plus feedback of the last forecast
  logic                  out_valid;
  omaf_pkg::candle_t     out_vals, prev_vals;
  omaf_pkg::job_ctrl_t   out_ctrl;

  assign s_axis_tready_o = !in_valid_q || in_take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tvalid_i && s_axis_tready_o) begin
      in_valid_q <= 1'b1;
    end else if (in_take) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      in_candle_q <= s_axis_tdata_i[CW-1:0];
      in_year_q   <= s_axis_tdata_i[CW +: omaf_pkg::YEAR_W];
      in_eos_q    <= s_axis_tlast_i;
    end
  end

  // sliding window, running sums, end-of-series burst sequencing
  omaf_window #(
    .WINDOW  (WINDOW),
    .HORIZON (HORIZON),
    .SUMW    (SUMW)
  ) u_window (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_q),
    .in_candle_i (in_candle_q),
    .in_year_i   (in_year_q),
    .in_eos_i    (in_eos_q),
    .in_take_o   (in_take),
    .prev_i      (prev_vals),
    .job_take_i  (job_take),
    .job_valid_o (job_valid),
    .job_sums_o  (job_sums),
    .job_ctrl_o  (job_ctrl)
  );

  // floored averages and the result register
  omaf_forecast #(
    .WINDOW (WINDOW),
    .SUMW   (SUMW)
  ) u_forecast (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (job_valid),
    .job_sums_i  (job_sums),
    .job_ctrl_i  (job_ctrl),
    .job_take_o  (job_take),
    .out_ready_i (m_axis_tready_i),
    .out_valid_o (out_valid),
    .out_vals_o  (out_vals),
    .out_ctrl_o  (out_ctrl),
    .prev_o      (prev_vals)
  );

  assign m_axis_tvalid_o = out_valid;
  assign m_axis_tdata_o  = {{(80 - CW - omaf_pkg::YEAR_W){1'b0}}, out_ctrl.year, out_vals};
  assign m_axis_tlast_o  = out_ctrl.last;
  assign m_axis_tuser_o  = out_ctrl.few;

`ifndef SYNTHESIS
  // a short series yields a single closing result with zeroed fields
  a_short_series: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o[0]) |-> (m_axis_tlast_o && m_axis_tdata_o == '0))
    else $error("short-series result malformed");

  // a job leaving the window stage lands in the result register with its last and too-few flags
  a_job_handoff: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_take |=> (m_axis_tvalid_o && m_axis_tuser_o[0] == $past(job_ctrl.few)
                  && m_axis_tlast_o == $past(job_ctrl.last)))
    else $error("forecast job lost between stages");

  // once the window stage consumes a candle, the input register holds one only if refilled
  a_take_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_take |=> !(in_valid_q && $past(!(s_axis_tvalid_i && s_axis_tready_o))))
    else $error("input register consumed without refill");
`endif

endmodule

`default_nettype wire
